// ----- rtl/core/pixel_color_blender_assert.svh -----
// assertion macros for the pixel color blender checker
`ifndef PIXEL_COLOR_BLENDER_ASSERT_SVH
`define PIXEL_COLOR_BLENDER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PCB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PCB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pcb_pkg.sv -----
// types, codes and shared functions of the pixel color blender
package pcb_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_BLEND   = 3'd0,
        REG_FOG     = 3'd1,
        REG_MUX     = 3'd2,
        REG_MODE    = 3'd3,
        REG_SHIFT_A = 3'd4,
        REG_SHIFT_B = 3'd5
    } t_reg_idx;

    // mode flag bit positions
    localparam int ModeTwo    = 0;
    localparam int ModeAcmp   = 1;
    localparam int ModeAa     = 2;
    localparam int ModeOnCvg  = 3;
    localparam int ModeForce  = 4;
    localparam int ModeRej1   = 5;
    localparam int ModeRej2   = 6;

    // color operand selects
    localparam logic [1:0] CSEL_PRIM  = 2'd0;
    localparam logic [1:0] CSEL_MEM   = 2'd1;
    localparam logic [1:0] CSEL_BLEND = 2'd2;
    localparam logic [1:0] CSEL_FOG   = 2'd3;

    // first alpha selects
    localparam logic [1:0] ASEL_PIX   = 2'd0;
    localparam logic [1:0] ASEL_FOG   = 2'd1;
    localparam logic [1:0] ASEL_SHADE = 2'd2;
    localparam logic [1:0] ASEL_ZERO  = 2'd3;

    // second alpha selects
    localparam logic [1:0] BSEL_INV   = 2'd0;
    localparam logic [1:0] BSEL_MEM   = 2'd1;
    localparam logic [1:0] BSEL_FULL  = 2'd2;
    localparam logic [1:0] BSEL_ZERO  = 2'd3;

    typedef enum logic [1:0] {
        PASS_EQ,
        PASS_FIRST,
        PASS_SECOND
    } t_pass;

    typedef struct packed {
        logic [31:0] pixel_rgba;
        logic [31:0] memory_rgba;
        logic [7:0]  shade_alpha;
        logic [3:0]  coverage_count;
        logic        coverage_bit;
        logic        color_wrapped;
        logic        blend_enable;
    } t_pix_in;

    typedef struct packed {
        logic       write_enable;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_pix_out;

    typedef struct packed {
        logic [4:0] a1;
        logic [5:0] mulb;
        logic [3:0] d;
    } t_alpha;

    // first-equation control, used in the first lane stage
    typedef struct packed {
        logic [1:0] c1;
        logic [1:0] c2;
        logic [4:0] a1;
        logic [5:0] mulb;
    } t_cyc0;

    // final-equation operand control, used in the second lane stage
    typedef struct packed {
        logic       two;
        logic [1:0] c1;
        logic [1:0] c2;
        logic [4:0] a1;
        logic [5:0] mulb;
    } t_cyc1;

    // result control, used in the third lane stage
    typedef struct packed {
        t_pass      mode;
        logic       divide;
        logic [3:0] d;
    } t_fin;

    // blend factors for one select byte
    function automatic t_alpha alpha_calc(input logic [7:0] sel, input logic [7:0] pix_a,
                                          input logic [7:0] mem_a, input logic [7:0] shade,
                                          input logic [7:0] fog_a, input logic [2:0] sha,
                                          input logic [2:0] shb);
        logic [7:0] a1f;
        logic [7:0] a2f;
        logic [4:0] a1;
        logic [4:0] a2;
        t_alpha     r;
        unique case (sel[3:2])
            ASEL_PIX:   a1f = pix_a;
            ASEL_FOG:   a1f = fog_a;
            ASEL_SHADE: a1f = shade;
            default:    a1f = 8'd0;
        endcase
        unique case (sel[7:6])
            BSEL_INV:  a2f = ~a1f;
            BSEL_MEM:  a2f = mem_a;
            BSEL_FULL: a2f = 8'hff;
            default:   a2f = 8'd0;
        endcase
        a1 = a1f[7:3];
        a2 = a2f[7:3];
        if (sel[7:6] == BSEL_MEM) begin
            a1 = (a1 >> sha) & 5'h1C;
            a2 = (a2 >> shb) | 5'd3;
        end
        r.a1   = a1;
        r.mulb = {1'b0, a2} + 6'd1;
        r.d    = {1'b0, a1[4:2]} + {1'b0, a2[4:2]} + 4'd1;
        return r;
    endfunction

    // one color channel chosen by a color select
    function automatic logic [7:0] pick_ch(input logic [1:0] code, input logic [7:0] prim,
                                           input logic [7:0] mem, input logic [7:0] bl,
                                           input logic [7:0] fog);
        logic [7:0] r;
        unique case (code)
            CSEL_PRIM:  r = prim;
            CSEL_MEM:   r = mem;
            CSEL_BLEND: r = bl;
            default:    r = fog;
        endcase
        return r;
    endfunction

    // eight-step non-restoring divide of the weighted sum
    function automatic logic [7:0] div_step(input logic [3:0] d, input logic [10:0] n);
        logic [7:0] res;
        logic [3:0] invd;
        logic [4:0] t;
        logic [2:0] part;
        logic       prev;
        res  = '0;
        invd = ~d;
        t    = {1'b0, invd} + {2'b0, n[10:8]} + 5'd1;
        part = t[2:0];
        prev = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (prev) begin
                t = {1'b0, invd} + {1'b0, part, 1'b0} + {4'b0, n[7-k]} + 5'd1;
            end else begin
                t = {1'b0, d} + {1'b0, part, 1'b0} + {4'b0, n[7-k]};
            end
            part       = t[2:0];
            prev       = t[4];
            res[7-k]   = t[4];
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/pcb_lane.sv -----
// one color channel lane: first equation, final equation, divide or shift
module pcb_lane (
    input  logic          i_clk,
    input  logic [7:0]    i_pix,
    input  logic [7:0]    i_mem,
    input  logic [7:0]    i_blend,
    input  logic [7:0]    i_fog,
    input  pcb_pkg::t_cyc0 i_c0,
    input  pcb_pkg::t_cyc1 i_c1,
    input  pcb_pkg::t_fin  i_fin,
    output logic [7:0]    o_res
);
    import pcb_pkg::*;

    logic [7:0]  p0, m0, p1, m1, prim, blended;
    logic [13:0] s0, s1;
    logic [13:0] r_s0, r_s1;
    logic [7:0]  r_pix, r_mem, r_p1, r_m1;

    // first equation weighted sum
    always_comb begin
        p0 = pick_ch(i_c0.c1, i_pix, i_mem, i_blend, i_fog);
        m0 = pick_ch(i_c0.c2, i_pix, i_mem, i_blend, i_fog);
        s0 = 14'(p0 * i_c0.a1) + 14'(m0 * i_c0.mulb);
    end

    always_ff @(posedge i_clk) begin
        r_s0  <= s0;
        r_pix <= i_pix;
        r_mem <= i_mem;
    end

    // final equation on the blended or the pixel color
    always_comb begin
        blended = r_s0[12:5];
        prim    = i_c1.two ? blended : r_pix;
        p1      = pick_ch(i_c1.c1, prim, r_mem, i_blend, i_fog);
        m1      = pick_ch(i_c1.c2, prim, r_mem, i_blend, i_fog);
        s1      = 14'(p1 * i_c1.a1) + 14'(m1 * i_c1.mulb);
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= s1;
        r_p1 <= p1;
        r_m1 <= m1;
    end

    // pass an operand, divide or shift
    always_comb begin
        unique case (i_fin.mode)
            PASS_FIRST:  o_res = r_p1;
            PASS_SECOND: o_res = r_m1;
            default:     o_res = i_fin.divide ? div_step(i_fin.d, r_s1[12:2]) : r_s1[12:5];
        endcase
    end

endmodule

// ----- rtl/core/pixel_color_blender.sv -----
// pixel color blender top level: config registers, control, lanes and merge
// One pixel is taken on every clock cycle once reset has been released, and its
// result is strobed on o_valid once it has passed the input register, the two
// lane stages (first equation multiply, final equation multiply) and the output
// register that follows the divide or shift. The receiver cannot stall, so o_busy
// is high only during reset and until the run flag is set after its release.
// Configuration writes are accepted whenever o_cfg_ready is high and must be
// made while no pixel is in flight.
module pixel_color_blender (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  pcb_pkg::t_pix_in                i_data,
    output logic                            o_valid,
    output pcb_pkg::t_pix_out               o_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pcb_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [pcb_pkg::CfgDataW-1:0]    i_cfg_data
);
    import pcb_pkg::*;

    logic        r_run;
    logic [31:0] r_blend, r_fog;
    logic [15:0] r_mux;
    logic [6:0]  r_mode;
    logic [2:0]  r_sha, r_shb;

    logic        r1_vld, r2_vld, r3_vld;
    t_pix_in     r1_in;
    logic        r2_wen, r3_wen;
    t_cyc1       r2_cyc1;
    t_fin        r2_fin, r3_fin;
    t_pix_out    r_out;
    logic        r_out_vld;

    logic        wen, two, reject;
    logic [7:0]  selb, pix_a;
    t_alpha      al0, al1;
    t_cyc0       c0;
    t_cyc1       c1;
    t_fin        fin;
    logic [7:0]  res [3];

    // run flag, low during reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign o_busy      = ~r_run;
    assign o_cfg_ready = r_run;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend <= '0;
            r_fog   <= '0;
            r_mux   <= '0;
            r_mode  <= '0;
            r_sha   <= '0;
            r_shb   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_BLEND:   r_blend <= i_cfg_data;
                REG_FOG:     r_fog   <= i_cfg_data;
                REG_MUX:     r_mux   <= i_cfg_data[15:0];
                REG_MODE:    r_mode  <= i_cfg_data[6:0];
                REG_SHIFT_A: r_sha   <= i_cfg_data[2:0];
                REG_SHIFT_B: r_shb   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_in <= i_data;
    end

    // per-pixel control: gating, blend factors and pass decisions
    always_comb begin
        pix_a  = r1_in.pixel_rgba[7:0];
        two    = r_mode[ModeTwo];
        reject = two ? r_mode[ModeRej2] : r_mode[ModeRej1];
        wen    = !(r_mode[ModeAcmp] && (pix_a < r_blend[7:0])) &&
                 (r_mode[ModeAa] ? (r1_in.coverage_count != 4'd0) : r1_in.coverage_bit);
        selb   = two ? r_mux[15:8] : r_mux[7:0];
        al0    = alpha_calc(r_mux[7:0], pix_a, r1_in.memory_rgba[7:0], r1_in.shade_alpha,
                            r_fog[7:0], r_sha, r_shb);
        al1    = alpha_calc(selb, pix_a, r1_in.memory_rgba[7:0], r1_in.shade_alpha,
                            r_fog[7:0], r_sha, r_shb);
        c0.c1   = r_mux[1:0];
        c0.c2   = r_mux[5:4];
        c0.a1   = al0.a1;
        c0.mulb = al0.mulb;
        c1.two  = two;
        c1.c1   = selb[1:0];
        c1.c2   = selb[5:4];
        c1.a1   = al1.a1;
        c1.mulb = al1.mulb;
        fin.divide = !r_mode[ModeForce];
        fin.d      = al1.d;
        if (r_mode[ModeOnCvg] && !r1_in.color_wrapped) begin
            fin.mode = PASS_SECOND;
        end else if (!r1_in.blend_enable || (reject && (pix_a == 8'hff))) begin
            fin.mode = PASS_FIRST;
        end else begin
            fin.mode = PASS_EQ;
        end
    end

    // control pipeline alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_wen  <= wen;
        r2_cyc1 <= c1;
        r2_fin  <= fin;
        r3_wen  <= r2_wen;
        r3_fin  <= r2_fin;
    end

    // red, green and blue lanes
    for (genvar l = 0; l < 3; l++) begin : g_lane
        pcb_lane u_lane (
            .i_clk   (i_clk),
            .i_pix   (r1_in.pixel_rgba[31-8*l -: 8]),
            .i_mem   (r1_in.memory_rgba[31-8*l -: 8]),
            .i_blend (r_blend[31-8*l -: 8]),
            .i_fog   (r_fog[31-8*l -: 8]),
            .i_c0    (c0),
            .i_c1    (r2_cyc1),
            .i_fin   (r3_fin),
            .o_res   (res[l])
        );
    end

    // merge lanes into the result transaction, rejected pixels read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.write_enable <= r3_wen;
        r_out.out_red      <= r3_wen ? res[0] : 8'd0;
        r_out.out_green    <= r3_wen ? res[1] : 8'd0;
        r_out.out_blue     <= r3_wen ? res[2] : 8'd0;
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// ----- rtl/core/pcb_checker.sv -----
// port checker for the pixel color blender and its bind
`include "pixel_color_blender_assert.svh"

module pcb_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            o_busy,
    input  pcb_pkg::t_pix_in                i_data,
    input  logic                            o_valid,
    input  pcb_pkg::t_pix_out               o_data,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [pcb_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [pcb_pkg::CfgDataW-1:0]    i_cfg_data
);
    import pcb_pkg::*;

    // every start transaction yields a result on o_valid
    `PCB_ASSERT_IMP(a_lat_fwd, i_start && !o_busy, ##4 o_valid, "result missing after start")

    // no result without an earlier start transaction
    `PCB_ASSERT_IMP(a_lat_bwd, o_valid, $past(i_start && !o_busy, 4), "result without start")

    // a rejected pixel carries no color
    `PCB_ASSERT_IMP(a_rej_zero, o_valid && !o_data.write_enable,
                    o_data.out_red == 8'd0 && o_data.out_green == 8'd0 &&
                    o_data.out_blue == 8'd0, "rejected pixel has color")

    // once running, the block never stalls either channel
    `PCB_ASSERT_NXT(a_no_stall, !o_busy, !o_busy && o_cfg_ready, "block stalled after reset")

endmodule

bind pixel_color_blender pcb_checker u_pcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_data      (i_data),
    .o_valid     (o_valid),
    .o_data      (o_data),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

// ----- test/pixel_color_blender_tb.sv -----
// testbench for the pixel color blender: directed table, then random pixels checked by a predictor
`timescale 1ns / 1ps

module pixel_color_blender_tb;
    import pcb_pkg::*;

    logic                clk_r;
    logic                rst_n_r;
    logic                start_r;
    logic                busy_w;
    t_pix_in             pix_r;
    logic                res_valid_w;
    t_pix_out            res_w;
    logic                cfg_valid_r;
    logic                cfg_ready_w;
    logic [CfgIdxW-1:0]  cfg_index_r;
    logic [CfgDataW-1:0] cfg_data_r;

    // predictor copy of the registers
    logic [31:0] blend_rgba;
    logic [31:0] fog_rgba;
    logic [15:0] selects;
    logic [6:0]  modes;
    logic [2:0]  shift_a;
    logic [2:0]  shift_b;

    t_pix_out    pending_pixels[$];
    int          fail_count;
    int          idle_cycles;
    int          item_count;
    bit          limit_hit;

    localparam int WatchdogLimit = 2000;

    pixel_color_blender DUT (
        .i_clk       (clk_r),
        .i_rst_n     (rst_n_r),
        .i_start     (start_r),
        .o_busy      (busy_w),
        .i_data      (pix_r),
        .o_valid     (res_valid_w),
        .o_data      (res_w),
        .i_cfg_valid (cfg_valid_r),
        .o_cfg_ready (cfg_ready_w),
        .i_cfg_index (cfg_index_r),
        .i_cfg_data  (cfg_data_r)
    );

    always #6 clk_r = ~clk_r;

    // non-restoring divide of the weighted sum
    function automatic logic [7:0] quotient(input logic [3:0] d, input logic [10:0] n);
        logic [7:0] q;
        logic [3:0] nd;
        logic [4:0] t;
        logic [2:0] part;
        q    = '0;
        nd   = ~d;
        t    = 5'(nd) + 5'(n[10:8]) + 5'd1;
        part = t[2:0];
        for (int k = 0; k < 8; k++) begin
            if (k == 0 ? 1'b0 : q[8-k])
                t = 5'(nd) + 5'({part, 1'b0}) + 5'(n[7-k]) + 5'd1;
            else
                t = 5'(d) + 5'({part, 1'b0}) + 5'(n[7-k]);
            part = t[2:0];
            if (t[4]) q[7-k] = 1'b1;
        end
        return q;
    endfunction

    function automatic logic [31:0] operand(input logic [1:0] s, input bit second,
                                            input logic [31:0] pix, input logic [31:0] mem,
                                            input logic [31:0] blended);
        case (s)
            CSEL_PRIM:  return second ? blended : pix;
            CSEL_MEM:   return mem;
            CSEL_BLEND: return blend_rgba;
            default:    return fog_rgba;
        endcase
    endfunction

    // one blend equation, channels packed as r,g,b in [31:8]
    function automatic logic [31:0] blend_eq(input bit second, input bit divide,
                                             input t_pix_in p, input logic [31:0] blended);
        logic [7:0]  s;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [7:0]  a1f;
        logic [7:0]  a2f;
        logic [31:0] a1;
        logic [31:0] a2;
        logic [31:0] sum;
        logic [31:0] w;
        logic [31:0] idx;
        logic [31:0] res;
        s  = second ? selects[15:8] : selects[7:0];
        c1 = operand(s[1:0], second, p.pixel_rgba, p.memory_rgba, blended);
        c2 = operand(s[5:4], second, p.pixel_rgba, p.memory_rgba, blended);
        case (s[3:2])
            ASEL_PIX:   a1f = p.pixel_rgba[7:0];
            ASEL_FOG:   a1f = fog_rgba[7:0];
            ASEL_SHADE: a1f = p.shade_alpha;
            default:    a1f = 8'd0;
        endcase
        case (s[7:6])
            BSEL_INV:  a2f = ~a1f;
            BSEL_MEM:  a2f = p.memory_rgba[7:0];
            BSEL_FULL: a2f = 8'hff;
            default:   a2f = 8'd0;
        endcase
        a1 = a1f >> 3;
        a2 = a2f >> 3;
        if (s[7:6] == BSEL_MEM) begin
            a1 = (a1 >> shift_a) & 32'h3C;
            a2 = (a2 >> shift_b) | 32'd3;
        end
        sum = ((a1 & ~32'd3) + (a2 & ~32'd3) + 32'd4) << 9;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            w = c1[31-8*ch -: 8] * a1 + c2[31-8*ch -: 8] * (a2 + 1);
            if (divide) begin
                idx = (sum | ((w >> 2) & 32'h7ff)) & 32'h7fff;
                res[31-8*ch -: 8] = quotient(idx[14:11], idx[10:0]);
            end else begin
                res[31-8*ch -: 8] = w[12:5];
            end
        end
        return res;
    endfunction

    function automatic t_pix_out blend_pixel(input t_pix_in p);
        t_pix_out    o;
        bit          two;
        bit          rej;
        logic [7:0]  s;
        logic [31:0] blended;
        logic [31:0] col;
        two     = modes[ModeTwo];
        rej     = modes[two ? ModeRej2 : ModeRej1];
        s       = two ? selects[15:8] : selects[7:0];
        blended = '0;
        o       = '0;
        if (modes[ModeAcmp] && p.pixel_rgba[7:0] < blend_rgba[7:0]) return o;
        if (modes[ModeAa] ? p.coverage_count == 0 : !p.coverage_bit) return o;
        if (two) blended = blend_eq(1'b0, 1'b0, p, '0);
        if (modes[ModeOnCvg] && !p.color_wrapped)
            col = operand(s[5:4], two, p.pixel_rgba, p.memory_rgba, blended);
        else if (!p.blend_enable || (rej && p.pixel_rgba[7:0] == 8'hff))
            col = operand(s[1:0], two, p.pixel_rgba, p.memory_rgba, blended);
        else
            col = blend_eq(two, !modes[ModeForce], p, blended);
        o.write_enable = 1'b1;
        o.out_red      = col[31:24];
        o.out_green    = col[23:16];
        o.out_blue     = col[15:8];
        return o;
    endfunction

    // register write, block idle; valid stays high for a following write
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        cfg_valid_r <= 1'b1;
        cfg_index_r <= idx;
        cfg_data_r  <= val;
        do @(posedge clk_r); while (!cfg_ready_w);
        case (idx)
            REG_BLEND:   blend_rgba = val;
            REG_FOG:     fog_rgba   = val;
            REG_MUX:     selects    = val[15:0];
            REG_MODE:    modes      = val[6:0];
            REG_SHIFT_A: shift_a    = val[2:0];
            default:     shift_b    = val[2:0];
        endcase
    endtask

    // wait for outstanding results plus pipeline drain
    task automatic drain();
        start_r <= 1'b0;
        while (pending_pixels.size() != 0 && !limit_hit) @(posedge clk_r);
        repeat (6) @(posedge clk_r);
    endtask

    task automatic set_config(input logic [31:0] bl, input logic [31:0] fg,
                              input logic [15:0] mx, input logic [6:0] md,
                              input logic [2:0] sa, input logic [2:0] sb);
        drain();
        write_reg(REG_BLEND, bl);
        write_reg(REG_FOG, fg);
        write_reg(REG_MUX, {16'(~mx), mx});
        write_reg(REG_MODE, {25'h1ffffff, md});
        write_reg(REG_SHIFT_A, {29'h0, sa});
        write_reg(REG_SHIFT_B, {29'h0, sb});
        cfg_valid_r <= 1'b0;
    endtask

    // send one pixel with an optional random gap; returns after the transaction
    task automatic send_pixel(input t_pix_in p, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0 && $urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start_r <= 1'b0;
            repeat (gap) @(posedge clk_r);
        end
        start_r <= 1'b1;
        pix_r   <= p;
        do @(posedge clk_r); while (busy_w);
        pending_pixels.push_back(blend_pixel(p));
        item_count++;
    endtask

    function automatic t_pix_in random_pixel();
        t_pix_in p;
        p.pixel_rgba     = $urandom;
        p.memory_rgba    = $urandom;
        p.shade_alpha    = 8'($urandom);
        p.coverage_count = 4'($urandom_range(0, 15));
        p.coverage_bit   = $urandom_range(0, 7) != 0;
        p.color_wrapped  = 1'($urandom_range(0, 1));
        p.blend_enable   = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 7) == 0) p.pixel_rgba[7:0] = 8'hff;
        return p;
    endfunction

    // result check against the oldest expectation
    always @(posedge clk_r) begin
        t_pix_out exp_px;
        if (rst_n_r && res_valid_w) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result transaction");
                fail_count++;
            end else begin
                exp_px = pending_pixels.pop_front();
                if (res_w.write_enable !== exp_px.write_enable) begin
                    $error("write_enable exp %0h got %0h", exp_px.write_enable,
                           res_w.write_enable);
                    fail_count++;
                end
                if (res_w.out_red !== exp_px.out_red) begin
                    $error("out_red exp %0h got %0h", exp_px.out_red, res_w.out_red);
                    fail_count++;
                end
                if (res_w.out_green !== exp_px.out_green) begin
                    $error("out_green exp %0h got %0h", exp_px.out_green, res_w.out_green);
                    fail_count++;
                end
                if (res_w.out_blue !== exp_px.out_blue) begin
                    $error("out_blue exp %0h got %0h", exp_px.out_blue, res_w.out_blue);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk_r) begin
        if (!rst_n_r || res_valid_w || (start_r && !busy_w) || (cfg_valid_r && cfg_ready_w))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            limit_hit = 1'b1;
            $display("pixel_color_blender test failed");
            $finish;
        end
    end

    typedef struct {
        t_pix_in  px;
        bit       typed;
        t_pix_out want;
    } t_row;

    initial begin
        t_row     rows[$];
        t_row     r;
        t_pix_out got;
        clk_r       = 1'b0;
        rst_n_r     = 1'b0;
        start_r     = 1'b0;
        pix_r       = '0;
        cfg_valid_r = 1'b0;
        cfg_index_r = '0;
        cfg_data_r  = '0;
        fail_count  = 0;
        idle_cycles = 0;
        item_count  = 0;
        limit_hit   = 1'b0;
        blend_rgba  = '0;
        fog_rgba    = '0;
        selects     = '0;
        modes       = '0;
        shift_a     = '0;
        shift_b     = '0;
        repeat (6) @(posedge clk_r);
        rst_n_r <= 1'b1;
        @(posedge clk_r);

        // directed rows under reset config: a coverage reject, pass-through with blend off
        r = '{px: '{32'hffffffff, 32'hffffffff, 8'hff, 4'd0, 1'b0, 1'b1, 1'b1},
              typed: 1, want: '0};
        rows.push_back(r);
        r = '{px: '{32'h12345678, 32'h0, 8'h0, 4'd0, 1'b1, 1'b0, 1'b0},
              typed: 1, want: '{1'b1, 8'h12, 8'h34, 8'h56}};
        rows.push_back(r);
        r = '{px: '{32'h0, 32'h0, 8'h0, 4'd15, 1'b1, 1'b1, 1'b1},
              typed: 1, want: '{1'b1, 8'h0, 8'h0, 8'h0}};
        rows.push_back(r);
        r = '{px: '{32'hffffffff, 32'hffffffff, 8'hff, 4'd8, 1'b1, 1'b1, 1'b1},
              typed: 0, want: '0};
        rows.push_back(r);
        r = '{px: '{32'h80402010, 32'h01020304, 8'h80, 4'd1, 1'b1, 1'b0, 1'b1},
              typed: 0, want: '0};
        rows.push_back(r);
        foreach (rows[i]) begin
            send_pixel(rows[i].px, 1'b0);
            if (rows[i].typed) begin
                got = pending_pixels[pending_pixels.size()-1];
                if (got !== rows[i].want) begin
                    $error("directed row %0d pixel exp %0h got %0h", i, rows[i].want, got);
                    fail_count++;
                end
            end
        end

        // directed config extremes with every select, flag and shift
        for (int c = 0; c < 8; c++) begin
            set_config(c[0] ? 32'hffffffff : 32'h00000080, c[1] ? 32'hffffffff : 32'h0,
                       16'({c[2:0], c[2:0], 2'(c), 2'(c+1), 2'(c+2), 2'(c+3)}),
                       7'(c * 19) | 7'h10 & 7'(c << 2), 3'(c), 3'(7 - c));
            for (int k = 0; k < 3; k++) send_pixel(random_pixel(), 1'b0);
        end
        set_config(32'h0, 32'h0, 16'h0, 7'h7f, 3'd7, 3'd7);
        send_pixel(random_pixel(), 1'b0);

        // random phases; sender waits for all results between them
        for (int ph = 0; ph < 16; ph++) begin
            set_config($urandom, $urandom, 16'($urandom), 7'($urandom), 3'($urandom),
                       3'($urandom));
            for (int k = 0; k < 25; k++) send_pixel(random_pixel(), ph % 2 == 1);
        end

        drain();
        if (fail_count == 0 && pending_pixels.size() == 0)
            $display("pixel_color_blender test passed");
        else
            $display("pixel_color_blender test failed");
        $finish;
    end
endmodule
